/* src/scaled_digit_glyph_renderer_top_defines.svh */
// assertion macros for the scaled digit glyph renderer
`ifndef SCALED_DIGIT_GLYPH_RENDERER_TOP_DEFINES_SVH
`define SCALED_DIGIT_GLYPH_RENDERER_TOP_DEFINES_SVH

// checked at every clock edge outside reset
`define SDGR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every clock edge, reset included
`define SDGR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* src/sdgr_pkg.sv */
// shared types, constants and font table of the scaled digit glyph renderer
`default_nettype none

package sdgr_pkg;

  localparam int unsigned COLOUR_W  = 16;
  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned SCALE_W   = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned POS_W     = 2;
  localparam int unsigned ROW_W     = 3;
  localparam int unsigned COL_W     = 3;

  localparam logic [SCALE_W-1:0] MAX_SCALE = 4'd15;
  localparam logic [COL_W-1:0]   LAST_COL  = 3'd4;
  localparam logic [ROW_W-1:0]   LAST_ROW  = 3'd7;
  localparam logic [POS_W-1:0]   LAST_POS  = 2'd2;

  localparam logic [COLOUR_W-1:0] TEXT_RESET  = 16'hFFFF;
  localparam logic [COLOUR_W-1:0] BG_RESET    = 16'h0000;
  localparam logic [SCALE_W-1:0]  SCALE_RESET = 4'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VALUE = 2'd0,
    REG_TEXT  = 2'd1,
    REG_BG    = 2'd2,
    REG_SCALE = 2'd3
  } cfg_reg_e;

  // column bytes of digits 0..9, bit r is glyph row r
  localparam logic [7:0] FONT_COLS [10][5] = '{
    '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E},
    '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
    '{8'h72, 8'h49, 8'h49, 8'h49, 8'h46},
    '{8'h21, 8'h41, 8'h49, 8'h4D, 8'h33},
    '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10},
    '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
    '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h31},
    '{8'h41, 8'h21, 8'h11, 8'h09, 8'h07},
    '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36},
    '{8'h46, 8'h49, 8'h49, 8'h29, 8'h1E}
  };

  typedef struct packed {
    logic [POS_W-1:0]   digit;
    logic [ROW_W-1:0]   row;
    logic [SCALE_W-1:0] row_rep;
    logic [COL_W-1:0]   col;
    logic [SCALE_W-1:0] col_rep;
  } ctr_t;

  typedef struct packed {
    logic [COLOUR_W-1:0] colour;
    logic [POS_W-1:0]    pos;
    logic                last_digit;
    logic                last_num;
  } pix_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] hund;
    logic [DIGIT_W-1:0] tens;
    logic [DIGIT_W-1:0] units;
  } digits_t;

  function automatic logic font_bit(logic [DIGIT_W-1:0] digit, logic [COL_W-1:0] col,
                                    logic [ROW_W-1:0] row);
    logic [7:0] cols;
    cols = FONT_COLS[digit][col];
    return cols[row];
  endfunction

endpackage

`default_nettype wire

/* src/sdgr_bcd.sv */
// splits a 16-bit value, taken modulo 1000, into three decimal digits
`default_nettype none

module sdgr_bcd
  import sdgr_pkg::*;
(
  input  logic [VALUE_W-1:0] value_i,
  output digits_t            digits_o
);

  logic [11:0]        folded;
  logic [9:0]         mod1000;
  logic [6:0]         rem100;
  logic [3:0]         rem10;
  logic [DIGIT_W-1:0] hund;
  logic [DIGIT_W-1:0] tens;

  // 1024 = 24 mod 1000
  always_comb begin
    folded = 12'({value_i[15:10], 4'b0000}) + 12'({value_i[15:10], 3'b000})
             + 12'(value_i[9:0]);
    if (folded >= 12'd2000) begin
      mod1000 = 10'(folded - 12'd2000);
    end else if (folded >= 12'd1000) begin
      mod1000 = 10'(folded - 12'd1000);
    end else begin
      mod1000 = folded[9:0];
    end
  end

  always_comb begin
    hund   = '0;
    rem100 = 7'(mod1000);
    for (int k = 1; k < 10; k++) begin
      if (mod1000 >= 10'(k * 100)) begin
        hund   = DIGIT_W'(k);
        rem100 = 7'(mod1000 - 10'(k * 100));
      end
    end
  end

  always_comb begin
    tens  = '0;
    rem10 = 4'(rem100);
    for (int k = 1; k < 10; k++) begin
      if (rem100 >= 7'(k * 10)) begin
        tens  = DIGIT_W'(k);
        rem10 = 4'(rem100 - 7'(k * 10));
      end
    end
  end

  assign digits_o.hund  = hund;
  assign digits_o.tens  = tens;
  assign digits_o.units = rem10;

endmodule

`default_nettype wire

/* src/sdgr_skid.sv */
// two-entry output register with skid slot for pixel transactions
`default_nettype none

module sdgr_skid
  import sdgr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  pix_t push_data_i,
  output logic full_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output pix_t out_data_o
);

`include "scaled_digit_glyph_renderer_top_defines.svh"

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  pix_t out_data_q, out_data_d;
  pix_t skid_data_q, skid_data_d;
  logic out_fire;

  assign out_fire = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (out_fire) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (!out_valid_q || out_fire) begin
      out_valid_d = push_i;
      out_data_d  = push_data_i;
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_data_d  = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `SDGR_ASSERT(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid slot filled while output empty")
  `SDGR_ASSERT(a_no_push_when_full, skid_valid_q |-> !push_i, "push while skid slot full")
  `SDGR_ASSERT(a_skid_drains, skid_valid_q && !out_stall_i |=> !skid_valid_q, "skid slot did not drain")

endmodule

`default_nettype wire

/* src/scaled_digit_glyph_renderer_top.sv */
// Scaled digit glyph renderer: emits the pixels of a three-digit number (value mod 1000,
// leading zeros kept) drawn in a 5x8 font magnified by scale_factor, one pixel per accepted
// transaction. The pixel counters and colour lookup sit between the counter registers and a
// two-entry output register, so a new transaction is taken every cycle while in_stall_o is
// low, and each result passes through that output register. in_stall_o rises
// only when both output entries hold pixels the sink has not taken. A restart transaction
// begins at the first pixel; an advance after the last pixel, or any transaction while
// scale_factor is zero, yields no pixel. Configuration writes are never stalled.
`default_nettype none

module scaled_digit_glyph_renderer_top
  import sdgr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  restart_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COLOUR_W-1:0]   pixel_colour_o,
  output logic [POS_W-1:0]      digit_position_o,
  output logic                  last_in_digit_o,
  output logic                  last_of_number_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

`include "scaled_digit_glyph_renderer_top_defines.svh"

  digits_t             digits_q, digits_d;
  digits_t             cfg_digits;
  logic [COLOUR_W-1:0] text_q, text_d;
  logic [COLOUR_W-1:0] bg_q, bg_d;
  logic [SCALE_W-1:0]  scale_q, scale_d;
  logic [SCALE_W-1:0]  scale;
  ctr_t                ctr_q, ctr_d;
  ctr_t                cur, nxt;
  logic                done_q, done_d;
  logic                cur_done, nxt_done;
  logic                in_fire, cfg_fire, emit;
  logic                crep_end, col_end, rrep_end, row_end, last_pos;
  logic [COL_W-1:0]    font_col;
  logic [DIGIT_W-1:0]  digit;
  pix_t                res, out_pix;

  assign in_fire     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  sdgr_bcd u_bcd (
    .value_i  (cfg_data_i),
    .digits_o (cfg_digits)
  );

  always_comb begin
    digits_d = digits_q;
    text_d   = text_q;
    bg_d     = bg_q;
    scale_d  = scale_q;
    if (cfg_fire) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_VALUE: digits_d = cfg_digits;
        REG_TEXT:  text_d   = cfg_data_i;
        REG_BG:    bg_d     = cfg_data_i;
        REG_SCALE: scale_d  = cfg_data_i[SCALE_W-1:0];
        default:   digits_d = digits_q;
      endcase
    end
  end

  assign scale = (scale_q > MAX_SCALE) ? MAX_SCALE : scale_q;

  always_comb begin
    cur      = restart_i ? '0 : ctr_q;
    cur_done = restart_i ? 1'b0 : done_q;
    emit     = (scale != '0) && !cur_done;

    crep_end = ({1'b0, cur.col_rep} + 5'd1) >= {1'b0, scale};
    rrep_end = ({1'b0, cur.row_rep} + 5'd1) >= {1'b0, scale};
    col_end  = cur.col >= LAST_COL;
    row_end  = cur.row >= LAST_ROW;
    last_pos = cur.digit >= LAST_POS;

    font_col = col_end ? LAST_COL : cur.col;
    case (cur.digit)
      2'd0:    digit = digits_q.hund;
      2'd1:    digit = digits_q.tens;
      default: digit = digits_q.units;
    endcase

    res.colour     = font_bit(digit, font_col, cur.row) ? text_q : bg_q;
    res.pos        = cur.digit;
    res.last_digit = crep_end && col_end && rrep_end && row_end;
    res.last_num   = res.last_digit && last_pos;

    nxt      = cur;
    nxt_done = cur_done;
    if (!crep_end) begin
      nxt.col_rep = cur.col_rep + 1'b1;
    end else begin
      nxt.col_rep = '0;
      if (!col_end) begin
        nxt.col = cur.col + 1'b1;
      end else begin
        nxt.col = '0;
        if (!rrep_end) begin
          nxt.row_rep = cur.row_rep + 1'b1;
        end else begin
          nxt.row_rep = '0;
          if (!row_end) begin
            nxt.row = cur.row + 1'b1;
          end else begin
            nxt.row = '0;
            if (!last_pos) begin
              nxt.digit = cur.digit + 1'b1;
            end else begin
              nxt.digit = '0;
              nxt_done  = 1'b1;
            end
          end
        end
      end
    end

    ctr_d  = ctr_q;
    done_d = done_q;
    if (in_fire) begin
      ctr_d  = emit ? nxt : cur;
      done_d = emit ? nxt_done : cur_done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digits_q <= '0;
      text_q   <= TEXT_RESET;
      bg_q     <= BG_RESET;
      scale_q  <= SCALE_RESET;
      ctr_q    <= '0;
      done_q   <= 1'b1;
    end else begin
      digits_q <= digits_d;
      text_q   <= text_d;
      bg_q     <= bg_d;
      scale_q  <= scale_d;
      ctr_q    <= ctr_d;
      done_q   <= done_d;
    end
  end

  sdgr_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_fire && emit),
    .push_data_i (res),
    .full_o      (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_pix)
  );

  assign pixel_colour_o   = out_pix.colour;
  assign digit_position_o = out_pix.pos;
  assign last_in_digit_o  = out_pix.last_digit;
  assign last_of_number_o = out_pix.last_num;

  `SDGR_ASSERT(a_done_after_last, in_fire && emit && res.last_num |=> done_q, "not idle after last pixel")
  `SDGR_ASSERT(a_ctr_range, ctr_q.col <= LAST_COL && ctr_q.digit <= LAST_POS, "counter out of range")
  `SDGR_ASSERT(a_last_num_flags, out_valid_o && last_of_number_o |-> last_in_digit_o && digit_position_o == LAST_POS, "inconsistent end flags")

endmodule

`default_nettype wire

/* tb/tb.sv */
// testbench for scaled_digit_glyph_renderer_top: directed table, then random runs checked by a predictor
`default_nettype none

module tb;
  import sdgr_pkg::*;

  localparam int unsigned ITEMS    = 1950;
  localparam int unsigned LIMIT    = 600000;
  localparam int unsigned N_STEPS  = 25;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_PIX} chk_e;

  typedef struct packed {
    row_kind_e            kind;
    cfg_reg_e             idx;
    logic [CFG_DATA_W-1:0] data;
    logic                 restart;
    chk_e                 how;
    pix_t                 pix;
  } step_t;

  localparam step_t DIRECTED [N_STEPS] = '{
    '{ROW_ITEM, REG_VALUE, 16'h0000, 1'b0, CHK_NONE,  {16'h0000, 2'd0, 1'b0, 1'b0}},
    '{ROW_ITEM, REG_VALUE, 16'h0000, 1'b1, CHK_PIX,   {16'h0000, 2'd0, 1'b0, 1'b0}},
    '{ROW_ITEM, REG_VALUE, 16'h0000, 1'b0, CHK_PIX,   {16'hFFFF, 2'd0, 1'b0, 1'b0}},
    '{ROW_ITEM, REG_VALUE, 16'h0000, 1'b0, CHK_MODEL, {16'h0000, 2'd0, 1'b0, 1'b0}},
    '{ROW_CFG,  REG_VALUE, 16'hFFFF, 1'b0, CHK_MODEL, {16'h0000, 2'd0, 1'b0, 1'b0}},
    '{ROW_CFG,  REG_TEXT,  16'h0000, 1'b0, CHK_MODEL, {16'h0000, 2'd0, 1'b0, 1'b0}},
    '{ROW_CFG,  REG_BG,    16'hFFFF, 1'b0, CHK_MODEL, {16'h0000, 2'd0, 1'b0, 1'b0}},
    '{ROW_ITEM, REG_VALUE, 16'h0000, 1'b1, CHK_PIX,   {16'h0000, 2'd0, 1'b0, 1'b0}},
    '{ROW_ITEM, REG_VALUE, 16'h0000, 1'b0, CHK_MODEL, {16'h0000, 2'd0, 1'b0, 1'b0}},
    '{ROW_CFG,  REG_SCALE, 16'h0000, 1'b0, CHK_MODEL, {16'h0000, 2'd0, 1'b0, 1'b0}},
    '{ROW_ITEM, REG_VALUE, 16'h0000, 1'b1, CHK_NONE,  {16'h0000, 2'd0, 1'b0, 1'b0}},
    '{ROW_ITEM, REG_VALUE, 16'h0000, 1'b0, CHK_NONE,  {16'h0000, 2'd0, 1'b0, 1'b0}},
    '{ROW_CFG,  REG_SCALE, 16'hFFFF, 1'b0, CHK_MODEL, {16'h0000, 2'd0, 1'b0, 1'b0}},
    '{ROW_ITEM, REG_VALUE, 16'h0000, 1'b0, CHK_PIX,   {16'h0000, 2'd0, 1'b0, 1'b0}},
    '{ROW_ITEM, REG_VALUE, 16'h0000, 1'b0, CHK_MODEL, {16'h0000, 2'd0, 1'b0, 1'b0}},
    '{ROW_ITEM, REG_VALUE, 16'h0000, 1'b0, CHK_MODEL, {16'h0000, 2'd0, 1'b0, 1'b0}},
    '{ROW_CFG,  REG_SCALE, 16'h0001, 1'b0, CHK_MODEL, {16'h0000, 2'd0, 1'b0, 1'b0}},
    '{ROW_ITEM, REG_VALUE, 16'h0000, 1'b0, CHK_MODEL, {16'h0000, 2'd0, 1'b0, 1'b0}},
    '{ROW_ITEM, REG_VALUE, 16'h0000, 1'b0, CHK_MODEL, {16'h0000, 2'd0, 1'b0, 1'b0}},
    '{ROW_CFG,  REG_VALUE, 16'h03E7, 1'b0, CHK_MODEL, {16'h0000, 2'd0, 1'b0, 1'b0}},
    '{ROW_CFG,  REG_TEXT,  16'hF800, 1'b0, CHK_MODEL, {16'h0000, 2'd0, 1'b0, 1'b0}},
    '{ROW_CFG,  REG_BG,    16'h001F, 1'b0, CHK_MODEL, {16'h0000, 2'd0, 1'b0, 1'b0}},
    '{ROW_ITEM, REG_VALUE, 16'h0000, 1'b1, CHK_PIX,   {16'h001F, 2'd0, 1'b0, 1'b0}},
    '{ROW_ITEM, REG_VALUE, 16'h0000, 1'b1, CHK_PIX,   {16'h001F, 2'd0, 1'b0, 1'b0}},
    '{ROW_ITEM, REG_VALUE, 16'h0000, 1'b0, CHK_MODEL, {16'h0000, 2'd0, 1'b0, 1'b0}}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic                  restart_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [COLOUR_W-1:0]   pixel_colour_o;
  logic [POS_W-1:0]      digit_position_o;
  logic                  last_in_digit_o;
  logic                  last_of_number_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  scaled_digit_glyph_renderer_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .restart_i        (restart_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .pixel_colour_o   (pixel_colour_o),
    .digit_position_o (digit_position_o),
    .last_in_digit_o  (last_in_digit_o),
    .last_of_number_o (last_of_number_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  // predictor copy of the registers and the draw position
  logic [VALUE_W-1:0]  num_cfg   = '0;
  logic [COLOUR_W-1:0] text_cfg  = TEXT_RESET;
  logic [COLOUR_W-1:0] bg_cfg    = BG_RESET;
  logic [SCALE_W-1:0]  scale_cfg = SCALE_RESET;
  ctr_t                cursor    = '0;
  logic                drawn_out = 1'b1;

  pix_t        pending_pixels [$];
  int unsigned fails = 0;
  int unsigned cycle_cnt = 0;
  int unsigned shown = 0;
  int unsigned idle_pct = 15;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= LIMIT);
    $display("scaled_digit_glyph_renderer_top verification failed");
    $finish;
  end

  function automatic logic next_pixel(input logic rs, output pix_t px);
    logic [SCALE_W-1:0] sc;
    logic [COL_W-1:0]   c;
    logic [7:0]         bits;
    int unsigned        v, dig;
    logic               crep_end, col_end, rrep_end, row_end, dig_end, last_pos;
    sc = (scale_cfg > MAX_SCALE) ? MAX_SCALE : scale_cfg;
    px = '0;
    if (rs) begin
      cursor = '0;
      drawn_out = 1'b0;
    end
    if (sc == 0 || drawn_out) return 1'b0;
    c = (cursor.col >= LAST_COL) ? LAST_COL : cursor.col;
    v = num_cfg % 1000;
    case (cursor.digit)
      2'd0: dig = v / 100;
      2'd1: dig = (v / 10) % 10;
      default: dig = v % 10;
    endcase
    bits = FONT_COLS[dig][c];
    crep_end = int'(cursor.col_rep) + 1 >= int'(sc);
    col_end  = cursor.col >= LAST_COL;
    rrep_end = int'(cursor.row_rep) + 1 >= int'(sc);
    row_end  = cursor.row >= LAST_ROW;
    dig_end  = crep_end && col_end && rrep_end && row_end;
    last_pos = cursor.digit >= LAST_POS;
    px.colour     = bits[cursor.row] ? text_cfg : bg_cfg;
    px.pos        = cursor.digit;
    px.last_digit = dig_end;
    px.last_num   = dig_end && last_pos;
    if (!crep_end) begin
      cursor.col_rep = cursor.col_rep + 1'b1;
    end else begin
      cursor.col_rep = '0;
      if (!col_end) begin
        cursor.col = cursor.col + 1'b1;
      end else begin
        cursor.col = '0;
        if (!rrep_end) begin
          cursor.row_rep = cursor.row_rep + 1'b1;
        end else begin
          cursor.row_rep = '0;
          if (!row_end) begin
            cursor.row = cursor.row + 1'b1;
          end else begin
            cursor.row = '0;
            if (!last_pos) begin
              cursor.digit = cursor.digit + 1'b1;
            end else begin
              cursor.digit = '0;
              drawn_out = 1'b1;
            end
          end
        end
      end
    end
    return 1'b1;
  endfunction

  task automatic drive_item(input logic rs, input chk_e how, input pix_t typed);
    pix_t px;
    logic made;
    cfg_valid_i <= 1'b0;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= rs;
    do @(posedge clk_i); while (in_stall_o);
    made = next_pixel(rs, px);
    case (how)
      CHK_MODEL: if (made) pending_pixels.push_back(px);
      CHK_PIX:   pending_pixels.push_back(typed);
      default: ;
    endcase
    shown++;
  endtask

  task automatic quiet_down();
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_VALUE: num_cfg   = data[VALUE_W-1:0];
      REG_TEXT:  text_cfg  = data[COLOUR_W-1:0];
      REG_BG:    bg_cfg    = data[COLOUR_W-1:0];
      REG_SCALE: scale_cfg = data[SCALE_W-1:0];
      default: ;
    endcase
  endtask

  // sink side stall bursts
  initial begin
    forever begin
      @(posedge clk_i);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    pix_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel transaction: colour %h position %0d",
               pixel_colour_o, digit_position_o);
        fails++;
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_colour_o !== want.colour) begin
          $error("pixel_colour expected %h got %h", want.colour, pixel_colour_o);
          fails++;
        end
        if (digit_position_o !== want.pos) begin
          $error("digit_position expected %0d got %0d", want.pos, digit_position_o);
          fails++;
        end
        if (last_in_digit_o !== want.last_digit) begin
          $error("last_in_digit expected %b got %b", want.last_digit, last_in_digit_o);
          fails++;
        end
        if (last_of_number_o !== want.last_num) begin
          $error("last_of_number expected %b got %b", want.last_num, last_of_number_o);
          fails++;
        end
      end
    end
  end

  initial begin
    step_t                 st;
    cfg_reg_e              idx;
    logic [CFG_DATA_W-1:0] data;
    int unsigned           n_writes, run_len, r, sc;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_STEPS; i++) begin
      st = DIRECTED[i];
      if (st.kind == ROW_CFG) begin
        quiet_down();
        write_reg(st.idx, st.data);
      end else begin
        drive_item(st.restart, st.how, st.pix);
      end
    end

    shown = 0;
    while (shown < ITEMS) begin
      quiet_down();
      if (shown + 250 >= ITEMS) begin
        idle_pct = 0;
      end else begin
        r = $urandom_range(0, 2);
        idle_pct = (r == 0) ? 0 : (r == 1) ? 8 : 25;
      end
      n_writes = $urandom_range(1, 4);
      repeat (n_writes) begin
        idx  = cfg_reg_e'($urandom_range(0, 3));
        data = CFG_DATA_W'($urandom);
        r    = $urandom_range(0, 99);
        case (idx)
          REG_VALUE: begin
            if (r < 6) data = 16'd0;
            else if (r < 12) data = 16'd999;
            else if (r < 18) data = 16'd1000;
            else if (r < 24) data = 16'hFFFF;
          end
          REG_SCALE: begin
            if (r < 4) sc = 0;
            else if (r < 72) sc = 1;
            else if (r < 88) sc = 2;
            else if (r < 94) sc = $urandom_range(3, 4);
            else if (r < 97) sc = 15;
            else sc = $urandom_range(5, 14);
            data[SCALE_W-1:0] = SCALE_W'(sc);
          end
          default: ;
        endcase
        write_reg(idx, data);
      end
      if ($urandom_range(0, 9) < 7) drive_item(1'b1, CHK_MODEL, '0);
      sc = scale_cfg;
      if (sc == 0) run_len = $urandom_range(3, 10);
      else if ($urandom_range(0, 2) == 0) run_len = 120 * sc * sc + $urandom_range(0, 4);
      else run_len = $urandom_range(5, 150);
      if (run_len > 520) run_len = 520;
      if (run_len > ITEMS - shown) run_len = ITEMS - shown;
      repeat (run_len) drive_item($urandom_range(0, 99) == 0, CHK_MODEL, '0);
    end

    quiet_down();
    repeat (8) @(posedge clk_i);
    if (fails == 0) begin
      $display("scaled_digit_glyph_renderer_top verification clean");
    end else begin
      $display("scaled_digit_glyph_renderer_top verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+src
src/sdgr_pkg.sv
src/sdgr_bcd.sv
src/sdgr_skid.sv
src/scaled_digit_glyph_renderer_top.sv
tb/tb.sv
